// ===== rtl/mtba_pkg.sv =====
// Shared constants and configuration codes of the bitmap alignment block.
package mtba_pkg;

    // Default sizing of the block
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MIN_LEVEL    = 16;
    localparam int DEF_PIXEL_BITS   = 16;

    // Port field widths
    localparam int PIX_IN_W    = 16;
    localparam int SHIFT_OUT_W = 6;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOV_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOV_HEIGHT = 2'd3;
    localparam logic [CFG_W-1:0]     CFG_SIZE_RESET = 9'd256;

    // Score arithmetic
    localparam int               SCORE_W     = 21;
    localparam int               SCALE_W     = 20;
    localparam int               SCORE_SCALE = 1000000;
    localparam logic [SCORE_W-1:0] NO_SCORE  = 21'h1FFFFF;

endpackage

// ===== rtl/mtba_pix_if.sv =====
// Pixel input channel: valid/ready handshake carrying mode and pixel.
interface mtba_pix_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic [mtba_pkg::PIX_IN_W-1:0]    pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink   (input valid, input mode, input pixel, output ready);
endinterface

// ===== rtl/mtba_res_if.sv =====
// Result channel: valid/ready handshake carrying the alignment shift.
interface mtba_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mtba_pkg::SHIFT_OUT_W-1:0] shift_x;
    logic signed [mtba_pkg::SHIFT_OUT_W-1:0] shift_y;

    modport source (output valid, output shift_x, output shift_y, input ready);
    modport sink   (input valid, input shift_x, input shift_y, output ready);
endinterface

// ===== rtl/mtba_pyr_mem.sv =====
// Pyramid store: one write port and one registered read port.
module mtba_pyr_mem #(
    parameter int DEPTH = 87382,
    parameter int AW    = 17,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_array [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata <= mem_array[raddr];
    end

endmodule

// ===== rtl/mtba_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mtba_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;

    // Shift one dividend bit into the remainder and subtract where it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W);
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== rtl/median_threshold_bitmap_align_unit.sv =====
// Operation: pixels load at one per cycle; after the last pixel the alignment runs
// per level: four reads and a write per shrunk pixel, PIXEL_BITS median passes,
// and nine scans, each followed by a divide when the overlap is not empty.
// Throughput: one pixel per cycle while loading; no input during alignment.
// Reset: sizes go to 256, load counters clear, result channel empties;
// pyramid memories are not cleared.
module median_threshold_bitmap_align_unit #(
    parameter int MAX_WIDTH      = mtba_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = mtba_pkg::DEF_MAX_HEIGHT,
    parameter int MIN_LEVEL_SIZE = mtba_pkg::DEF_MIN_LEVEL,
    parameter int PIXEL_BITS     = mtba_pkg::DEF_PIXEL_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mtba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtba_pkg::CFG_W-1:0]       cfg_data,
    mtba_pix_if.sink                         pix_ch,
    mtba_res_if.source                       res_ch
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int AREA    = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH   = AREA + AREA / 3 + 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(AREA + 1);
    localparam int LVL_N   = $clog2(MAX_WIDTH);
    localparam int LVL_W   = $clog2(LVL_N);
    localparam int SW      = DIM_W + 2;
    localparam int PB      = PIXEL_BITS;
    localparam int BIT_W   = $clog2(PIXEL_BITS);
    localparam int PW      = CNT_W + mtba_pkg::SCALE_W;
    localparam int SC_W    = mtba_pkg::SCORE_W;

    typedef enum logic [14:0] {
        S_LOAD  = 15'b000000000000001,
        S_LVL   = 15'b000000000000010,
        S_LVLB  = 15'b000000000000100,
        S_SHR   = 15'b000000000001000,
        S_LOADL = 15'b000000000010000,
        S_MED   = 15'b000000000100000,
        S_MEDU  = 15'b000000001000000,
        S_SSET  = 15'b000000010000000,
        S_SCAN  = 15'b000000100000000,
        S_SEND  = 15'b000001000000000,
        S_MUL   = 15'b000010000000000,
        S_DIV   = 15'b000100000000000,
        S_DIVW  = 15'b001000000000000,
        S_CMP   = 15'b010000000000000,
        S_FIN   = 15'b100000000000000
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mtba_pkg::CFG_W-1:0] v,
                                                   input int maxv);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        if (int'(v) > maxv)
        begin
            return DIM_W'(maxv);
        end
        return DIM_W'(v);
    endfunction

    state_t state_reg, state_next;

    // Configuration
    logic [mtba_pkg::CFG_W-1:0] rwc_reg, rwc_next, rhc_reg, rhc_next;
    logic [mtba_pkg::CFG_W-1:0] mwc_reg, mwc_next, mhc_reg, mhc_next;
    logic [DIM_W-1:0] rw0, rh0, mw0, mh0;

    // Loading
    logic [DIM_W-1:0] rlx_reg, rlx_next, rly_reg, rly_next;
    logic [DIM_W-1:0] mlx_reg, mlx_next, mly_reg, mly_next;
    logic [AW-1:0]    rcnt_reg, rcnt_next, mcnt_reg, mcnt_next;

    // Current level
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [DIM_W-1:0] crw_reg, crw_next, crh_reg, crh_next;
    logic [DIM_W-1:0] cmw_reg, cmw_next, cmh_reg, cmh_next;
    logic [AW-1:0]    cro_reg, cro_next, cmo_reg, cmo_next;
    logic [CNT_W-1:0] crn_reg, crn_next, cmn_reg, cmn_next;

    // Level table
    logic [DIM_W-1:0] lv_rw_reg [LVL_N];
    logic [DIM_W-1:0] lv_rh_reg [LVL_N];
    logic [DIM_W-1:0] lv_mw_reg [LVL_N];
    logic [DIM_W-1:0] lv_mh_reg [LVL_N];
    logic [AW-1:0]    lv_ro_reg [LVL_N];
    logic [AW-1:0]    lv_mo_reg [LVL_N];
    logic [CNT_W-1:0] lv_rn_reg [LVL_N];
    logic [CNT_W-1:0] lv_mn_reg [LVL_N];

    // Shrink
    logic             sel_reg, sel_next;
    logic [DIM_W-1:0] sw_reg, sw_next, dw_reg, dw_next, dh_reg, dh_next;
    logic [DIM_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [AW-1:0]    srow_reg, srow_next, sptr_reg, sptr_next, dptr_reg, dptr_next;
    logic [2:0]       ph_reg, ph_next;
    logic [PB+1:0]    acc_reg, acc_next;

    // Median search
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [PB-1:0]    resr_reg, resr_next, resm_reg, resm_next;
    logic [CNT_W-1:0] idx_reg, idx_next, belr_reg, belr_next, belm_reg, belm_next;
    logic             vr1_reg, vr1_next, vm1_reg, vm1_next;
    logic [PB-1:0]    thrr_reg, thrr_next, thrm_reg, thrm_next;

    // Shift search
    logic signed [SW-1:0] runx_reg, runx_next, runy_reg, runy_next;
    logic signed [SW-1:0] bestx_reg, bestx_next, besty_reg, besty_next;
    logic signed [SW-1:0] cx_reg, cx_next, cy_reg, cy_next, my_reg, my_next;
    logic signed [1:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic [SC_W-1:0]      best_reg, best_next;
    logic [DIM_W-1:0]     x_reg, x_next, y_reg, y_next;
    logic [AW-1:0]        rptr_reg, rptr_next, mrow_reg, mrow_next;
    logic [CNT_W-1:0]     mism_reg, mism_next, ovl_reg, ovl_next;
    logic                 v1_reg, v1_next, ov1_reg, ov1_next;
    logic [PW-1:0]        prod_reg, prod_next;

    // Result
    logic                               oval_reg, oval_next;
    logic [mtba_pkg::SHIFT_OUT_W-1:0]   outx_reg, outx_next, outy_reg, outy_next;

    // Memory ports
    logic          r_we, m_we;
    logic [AW-1:0] r_waddr, m_waddr, r_raddr, m_raddr;
    logic [PB-1:0] r_wdata, m_wdata, r_rdata, m_rdata;

    // Divider
    logic          div_start, div_done;
    logic [PW-1:0] div_quo;

    mtba_pyr_mem #(.DEPTH(DEPTH), .AW(AW), .DW(PB)) u_ref_mem (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    mtba_pyr_mem #(.DEPTH(DEPTH), .AW(AW), .DW(PB)) u_mov_mem (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    mtba_div #(.NUM_W(PW), .DEN_W(CNT_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (ovl_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign rw0 = clamp_dim(rwc_reg, MAX_WIDTH);
    assign rh0 = clamp_dim(rhc_reg, MAX_HEIGHT);
    assign mw0 = clamp_dim(mwc_reg, MAX_WIDTH);
    assign mh0 = clamp_dim(mhc_reg, MAX_HEIGHT);

    assign pix_ch.ready   = (state_reg == S_LOAD);
    assign res_ch.valid   = oval_reg;
    assign res_ch.shift_x = $signed(outx_reg);
    assign res_ch.shift_y = $signed(outy_reg);

    // Sequencer and shared datapath
    always_comb
    begin
        logic [PB-1:0]        pix_v;
        logic [PB-1:0]        rd_sel;
        logic [PB+1:0]        sum;
        logic [PB-1:0]        candr, candm, newr, newm;
        logic [CNT_W-1:0]     nmax;
        logic signed [SW-1:0] cxc, cyc, mxs;
        logic                 inb, go_lvl, lvl_done;
        logic [SC_W-1:0]      e;
        logic [SC_W-1:0]      nbest;
        logic signed [SW-1:0] nbx, nby;

        state_next = state_reg;
        rwc_next = rwc_reg; rhc_next = rhc_reg; mwc_next = mwc_reg; mhc_next = mhc_reg;
        rlx_next = rlx_reg; rly_next = rly_reg; mlx_next = mlx_reg; mly_next = mly_reg;
        rcnt_next = rcnt_reg; mcnt_next = mcnt_reg;
        lvl_next = lvl_reg;
        crw_next = crw_reg; crh_next = crh_reg; cmw_next = cmw_reg; cmh_next = cmh_reg;
        cro_next = cro_reg; cmo_next = cmo_reg; crn_next = crn_reg; cmn_next = cmn_reg;
        sel_next = sel_reg; sw_next = sw_reg; dw_next = dw_reg; dh_next = dh_reg;
        sx_next = sx_reg; sy_next = sy_reg;
        srow_next = srow_reg; sptr_next = sptr_reg; dptr_next = dptr_reg;
        ph_next = ph_reg; acc_next = acc_reg;
        bit_next = bit_reg; resr_next = resr_reg; resm_next = resm_reg;
        idx_next = idx_reg; belr_next = belr_reg; belm_next = belm_reg;
        vr1_next = 1'b0; vm1_next = 1'b0;
        thrr_next = thrr_reg; thrm_next = thrm_reg;
        runx_next = runx_reg; runy_next = runy_reg;
        bestx_next = bestx_reg; besty_next = besty_reg; best_next = best_reg;
        cx_next = cx_reg; cy_next = cy_reg; my_next = my_reg;
        ox_next = ox_reg; oy_next = oy_reg;
        x_next = x_reg; y_next = y_reg;
        rptr_next = rptr_reg; mrow_next = mrow_reg;
        mism_next = mism_reg; ovl_next = ovl_reg;
        v1_next = 1'b0; ov1_next = 1'b0;
        prod_next = prod_reg;
        oval_next = oval_reg && !res_ch.ready;
        outx_next = outx_reg; outy_next = outy_reg;

        r_we = 1'b0; m_we = 1'b0;
        r_waddr = rcnt_reg; m_waddr = mcnt_reg;
        pix_v = PB'(pix_ch.pixel);
        r_wdata = pix_v; m_wdata = pix_v;
        r_raddr = rptr_reg; m_raddr = mrow_reg;
        div_start = 1'b0;

        rd_sel = sel_reg ? m_rdata : r_rdata;
        sum = acc_reg + (PB+2)'(rd_sel);
        candr = resr_reg | (PB'(1) << bit_reg);
        candm = resm_reg | (PB'(1) << bit_reg);
        newr = (belr_reg <= (crn_reg >> 1)) ? candr : resr_reg;
        newm = (belm_reg <= (cmn_reg >> 1)) ? candm : resm_reg;
        nmax = (crn_reg > cmn_reg) ? crn_reg : cmn_reg;
        cxc = runx_reg + SW'(ox_reg);
        cyc = runy_reg + SW'(oy_reg);
        mxs = cx_reg + $signed({2'b00, x_reg});
        inb = (my_reg >= 0) && (my_reg < $signed({2'b00, cmh_reg}))
              && (mxs >= 0) && (mxs < $signed({2'b00, cmw_reg}));
        go_lvl = 1'b0;
        lvl_done = 1'b0;
        e = (ovl_reg == '0) ? mtba_pkg::NO_SCORE : div_quo[SC_W-1:0];
        nbest = best_reg; nbx = bestx_reg; nby = besty_reg;

        // Count median candidates and scan mismatches from last cycle's reads
        if (vr1_reg && (r_rdata < candr))
        begin
            belr_next = belr_reg + CNT_W'(1);
        end
        if (vm1_reg && (m_rdata < candm))
        begin
            belm_next = belm_reg + CNT_W'(1);
        end
        if (v1_reg && ov1_reg)
        begin
            ovl_next = ovl_reg + CNT_W'(1);
            if ((r_rdata > thrr_reg) != (m_rdata > thrm_reg))
            begin
                mism_next = mism_reg + CNT_W'(1);
            end
        end

        case (state_reg)
            S_LOAD:
            begin
                // Store accepted pixels until both images are complete
                if (pix_ch.valid)
                begin
                    if (!pix_ch.mode && (rly_reg != rh0))
                    begin
                        r_we = 1'b1;
                        rcnt_next = rcnt_reg + AW'(1);
                        if (rlx_reg == rw0 - DIM_W'(1))
                        begin
                            rlx_next = '0;
                            rly_next = rly_reg + DIM_W'(1);
                        end
                        else
                        begin
                            rlx_next = rlx_reg + DIM_W'(1);
                        end
                    end
                    if (pix_ch.mode && (mly_reg != mh0))
                    begin
                        m_we = 1'b1;
                        mcnt_next = mcnt_reg + AW'(1);
                        if (mlx_reg == mw0 - DIM_W'(1))
                        begin
                            mlx_next = '0;
                            mly_next = mly_reg + DIM_W'(1);
                        end
                        else
                        begin
                            mlx_next = mlx_reg + DIM_W'(1);
                        end
                    end
                    if ((rly_next == rh0) && (mly_next == mh0))
                    begin
                        rlx_next = '0; rly_next = '0; rcnt_next = '0;
                        mlx_next = '0; mly_next = '0; mcnt_next = '0;
                        crw_next = rw0; crh_next = rh0; cmw_next = mw0; cmh_next = mh0;
                        cro_next = '0; cmo_next = '0;
                        lvl_next = '0;
                        runx_next = '0; runy_next = '0;
                        state_next = S_LVL;
                    end
                end
            end
            S_LVL:
            begin
                // Record level sizes
                crn_next = CNT_W'(crw_reg * crh_reg);
                cmn_next = CNT_W'(cmw_reg * cmh_reg);
                state_next = S_LVLB;
            end
            S_LVLB:
            begin
                // Build another level or start the search
                if ((int'(crw_reg) > MIN_LEVEL_SIZE) && (int'(crh_reg) > MIN_LEVEL_SIZE)
                    && (int'(lvl_reg) < LVL_N - 1))
                begin
                    sel_next = 1'b0;
                    sw_next = crw_reg; dw_next = crw_reg >> 1; dh_next = crh_reg >> 1;
                    srow_next = cro_reg; sptr_next = cro_reg;
                    dptr_next = cro_reg + AW'(crn_reg);
                    sx_next = '0; sy_next = '0; ph_next = '0;
                    state_next = S_SHR;
                end
                else
                begin
                    state_next = S_LOADL;
                end
            end
            S_SHR:
            begin
                // Four reads, accumulate, write the truncated average
                case (ph_reg)
                    3'd0: r_raddr = sptr_reg;
                    3'd1: r_raddr = sptr_reg + AW'(1);
                    3'd2: r_raddr = sptr_reg + AW'(sw_reg);
                    3'd3: r_raddr = sptr_reg + AW'(sw_reg) + AW'(1);
                    default: r_raddr = sptr_reg;
                endcase
                m_raddr = r_raddr;
                if (ph_reg == 3'd1)
                begin
                    acc_next = (PB+2)'(rd_sel);
                end
                else if (ph_reg != 3'd0)
                begin
                    acc_next = sum;
                end
                if (ph_reg == 3'd4)
                begin
                    r_waddr = dptr_reg; m_waddr = dptr_reg;
                    r_wdata = PB'(sum >> 2); m_wdata = PB'(sum >> 2);
                    r_we = !sel_reg; m_we = sel_reg;
                    ph_next = '0;
                    dptr_next = dptr_reg + AW'(1);
                    if (sx_reg == dw_reg - DIM_W'(1))
                    begin
                        sx_next = '0;
                        sy_next = sy_reg + DIM_W'(1);
                        srow_next = srow_reg + AW'(sw_reg) + AW'(sw_reg);
                        sptr_next = srow_reg + AW'(sw_reg) + AW'(sw_reg);
                        if (sy_reg == dh_reg - DIM_W'(1))
                        begin
                            if (!sel_reg)
                            begin
                                sel_next = 1'b1;
                                sw_next = cmw_reg; dw_next = cmw_reg >> 1;
                                dh_next = cmh_reg >> 1;
                                srow_next = cmo_reg; sptr_next = cmo_reg;
                                dptr_next = cmo_reg + AW'(cmn_reg);
                                sx_next = '0; sy_next = '0;
                                if (((cmw_reg >> 1) == '0) || ((cmh_reg >> 1) == '0))
                                begin
                                    go_lvl = 1'b1;
                                end
                            end
                            else
                            begin
                                go_lvl = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        sx_next = sx_reg + DIM_W'(1);
                        sptr_next = sptr_reg + AW'(2);
                    end
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
                if (go_lvl)
                begin
                    crw_next = crw_reg >> 1; crh_next = crh_reg >> 1;
                    cmw_next = cmw_reg >> 1; cmh_next = cmh_reg >> 1;
                    cro_next = cro_reg + AW'(crn_reg);
                    cmo_next = cmo_reg + AW'(cmn_reg);
                    lvl_next = lvl_reg + LVL_W'(1);
                    state_next = S_LVL;
                end
            end
            S_LOADL:
            begin
                // Fetch level and double the running shift
                crw_next = lv_rw_reg[lvl_reg]; crh_next = lv_rh_reg[lvl_reg];
                cmw_next = lv_mw_reg[lvl_reg]; cmh_next = lv_mh_reg[lvl_reg];
                cro_next = lv_ro_reg[lvl_reg]; cmo_next = lv_mo_reg[lvl_reg];
                crn_next = lv_rn_reg[lvl_reg]; cmn_next = lv_mn_reg[lvl_reg];
                runx_next = runx_reg <<< 1;
                runy_next = runy_reg <<< 1;
                bit_next = BIT_W'(PB - 1);
                resr_next = '0; resm_next = '0;
                idx_next = '0; belr_next = '0; belm_next = '0;
                state_next = S_MED;
            end
            S_MED:
            begin
                // One pass over both levels, counting pixels below the candidate
                r_raddr = cro_reg + AW'(idx_reg);
                m_raddr = cmo_reg + AW'(idx_reg);
                if (idx_reg < nmax)
                begin
                    vr1_next = (idx_reg < crn_reg);
                    vm1_next = (idx_reg < cmn_reg);
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_MEDU;
                end
            end
            S_MEDU:
            begin
                // Settle one threshold bit
                idx_next = '0; belr_next = '0; belm_next = '0;
                if (bit_reg == '0)
                begin
                    thrr_next = newr;
                    thrm_next = (cmn_reg == '0) ? '0 : newm;
                    best_next = mtba_pkg::NO_SCORE;
                    bestx_next = runx_reg; besty_next = runy_reg;
                    ox_next = -2'sd1; oy_next = -2'sd1;
                    state_next = S_SSET;
                end
                else
                begin
                    resr_next = newr; resm_next = newm;
                    bit_next = bit_reg - BIT_W'(1);
                    state_next = S_MED;
                end
            end
            S_SSET:
            begin
                // Set up one candidate shift
                cx_next = cxc; cy_next = cyc; my_next = cyc;
                mrow_next = cmo_reg + AW'(cyc * $signed({1'b0, cmw_reg}));
                x_next = '0; y_next = '0;
                rptr_next = cro_reg;
                mism_next = '0; ovl_next = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Walk the reference level, reading the overlapped moving pixel
                r_raddr = rptr_reg;
                m_raddr = mrow_reg + AW'($unsigned(mxs));
                v1_next = 1'b1;
                ov1_next = inb;
                rptr_next = rptr_reg + AW'(1);
                if (x_reg == crw_reg - DIM_W'(1))
                begin
                    x_next = '0;
                    y_next = y_reg + DIM_W'(1);
                    my_next = my_reg + SW'(1);
                    mrow_next = mrow_reg + AW'(cmw_reg);
                    if (y_reg == crh_reg - DIM_W'(1))
                    begin
                        state_next = S_SEND;
                    end
                end
                else
                begin
                    x_next = x_reg + DIM_W'(1);
                end
            end
            S_SEND:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = PW'(mism_reg) * PW'(mtba_pkg::SCORE_SCALE);
                state_next = (ovl_reg == '0) ? S_CMP : S_DIV;
            end
            S_DIV:
            begin
                div_start = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // Keep the first strict minimum, step to the next shift
                if (e < best_reg)
                begin
                    nbest = e; nbx = cx_reg; nby = cy_reg;
                end
                best_next = nbest; bestx_next = nbx; besty_next = nby;
                if (ox_reg == 2'sd1)
                begin
                    ox_next = -2'sd1;
                    if (oy_reg == 2'sd1)
                    begin
                        lvl_done = 1'b1;
                    end
                    else
                    begin
                        oy_next = oy_reg + 2'sd1;
                    end
                end
                else
                begin
                    ox_next = ox_reg + 2'sd1;
                end
                if (lvl_done)
                begin
                    runx_next = nbx; runy_next = nby;
                    if (lvl_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - LVL_W'(1);
                        state_next = S_LOADL;
                    end
                end
                else
                begin
                    state_next = S_SSET;
                end
            end
            S_FIN:
            begin
                // Hand the shift to the output register once it is free
                if (!oval_reg || res_ch.ready)
                begin
                    oval_next = 1'b1;
                    outx_next = runx_reg[mtba_pkg::SHIFT_OUT_W-1:0];
                    outy_next = runy_reg[mtba_pkg::SHIFT_OUT_W-1:0];
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Register write restarts loading of both images
        if (cfg_we)
        begin
            case (cfg_index)
                mtba_pkg::CFG_REF_WIDTH:  rwc_next = cfg_data;
                mtba_pkg::CFG_REF_HEIGHT: rhc_next = cfg_data;
                mtba_pkg::CFG_MOV_WIDTH:  mwc_next = cfg_data;
                mtba_pkg::CFG_MOV_HEIGHT: mhc_next = cfg_data;
                default: rwc_next = rwc_reg;
            endcase
            rlx_next = '0; rly_next = '0; rcnt_next = '0;
            mlx_next = '0; mly_next = '0; mcnt_next = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            rwc_reg <= mtba_pkg::CFG_SIZE_RESET;
            rhc_reg <= mtba_pkg::CFG_SIZE_RESET;
            mwc_reg <= mtba_pkg::CFG_SIZE_RESET;
            mhc_reg <= mtba_pkg::CFG_SIZE_RESET;
            rlx_reg <= '0; rly_reg <= '0; rcnt_reg <= '0;
            mlx_reg <= '0; mly_reg <= '0; mcnt_reg <= '0;
            lvl_reg <= '0;
            ph_reg <= '0;
            vr1_reg <= 1'b0; vm1_reg <= 1'b0;
            v1_reg <= 1'b0; ov1_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rwc_reg <= rwc_next; rhc_reg <= rhc_next;
            mwc_reg <= mwc_next; mhc_reg <= mhc_next;
            rlx_reg <= rlx_next; rly_reg <= rly_next; rcnt_reg <= rcnt_next;
            mlx_reg <= mlx_next; mly_reg <= mly_next; mcnt_reg <= mcnt_next;
            lvl_reg <= lvl_next;
            ph_reg <= ph_next;
            vr1_reg <= vr1_next; vm1_reg <= vm1_next;
            v1_reg <= v1_next; ov1_reg <= ov1_next;
            oval_reg <= oval_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        crw_reg <= crw_next; crh_reg <= crh_next; cmw_reg <= cmw_next; cmh_reg <= cmh_next;
        cro_reg <= cro_next; cmo_reg <= cmo_next; crn_reg <= crn_next; cmn_reg <= cmn_next;
        sel_reg <= sel_next; sw_reg <= sw_next; dw_reg <= dw_next; dh_reg <= dh_next;
        sx_reg <= sx_next; sy_reg <= sy_next;
        srow_reg <= srow_next; sptr_reg <= sptr_next; dptr_reg <= dptr_next;
        acc_reg <= acc_next;
        bit_reg <= bit_next; resr_reg <= resr_next; resm_reg <= resm_next;
        idx_reg <= idx_next; belr_reg <= belr_next; belm_reg <= belm_next;
        thrr_reg <= thrr_next; thrm_reg <= thrm_next;
        runx_reg <= runx_next; runy_reg <= runy_next;
        bestx_reg <= bestx_next; besty_reg <= besty_next; best_reg <= best_next;
        cx_reg <= cx_next; cy_reg <= cy_next; my_reg <= my_next;
        ox_reg <= ox_next; oy_reg <= oy_next;
        x_reg <= x_next; y_reg <= y_next;
        rptr_reg <= rptr_next; mrow_reg <= mrow_next;
        mism_reg <= mism_next; ovl_reg <= ovl_next;
        prod_reg <= prod_next;
        outx_reg <= outx_next; outy_reg <= outy_next;
    end

    // Level table, written once per level while building
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LVL)
        begin
            lv_rw_reg[lvl_reg] <= crw_reg;
            lv_rh_reg[lvl_reg] <= crh_reg;
            lv_mw_reg[lvl_reg] <= cmw_reg;
            lv_mh_reg[lvl_reg] <= cmh_reg;
            lv_ro_reg[lvl_reg] <= cro_reg;
            lv_mo_reg[lvl_reg] <= cmo_reg;
            lv_rn_reg[lvl_reg] <= CNT_W'(crw_reg * crh_reg);
            lv_mn_reg[lvl_reg] <= CNT_W'(cmw_reg * cmh_reg);
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the median threshold bitmap alignment unit.
`timescale 1ns / 100ps

module tb_top;
    import mtba_pkg::*;

    localparam int PYR_DEPTH   = 87296;
    localparam int MAX_LEV     = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_PAUSE  = 300;
    localparam int RAND_ITEMS  = 700;
    localparam int MIN_RESULTS = 40;
    localparam int LONG_HOLD   = 4000;

    typedef struct packed {
        logic signed [SHIFT_OUT_W-1:0] sx;
        logic signed [SHIFT_OUT_W-1:0] sy;
    } shift_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       val;
        logic                   mode;
        logic [PIX_IN_W-1:0]    pixel;
        bit                     has_exp;
        shift_t                 exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    mtba_pix_if pix ();
    mtba_res_if res ();

    median_threshold_bitmap_align_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_ch    (pix),
        .res_ch    (res)
    );

    // Clock: 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state
    logic [CFG_W-1:0] size_reg [4];
    int unsigned ref_count, mov_count;
    int unsigned ref_img [PYR_DEPTH];
    int unsigned mov_img [PYR_DEPTH];

    shift_t pending_shifts [$];
    row_t   dir_rows [$];
    int     errors = 0;
    int     results_seen = 0;
    int     pixels_stored = 0;
    int     cfg_writes = 0;
    int     cycles = 0;
    bit     quiet = 1'b0;
    bit     rand_phase = 1'b0;
    logic   long_hold = 1'b0;
    int     stall_left = 0;

    function automatic int clamp_dim(int v, int maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int unsigned pyr_at(bit is_mov, int a);
        return is_mov ? mov_img[a] : ref_img[a];
    endfunction

    // Build one level by 2x2 box averages, truncated
    function automatic void shrink_level(bit is_mov, int so, int sw, int sh, int dof);
        int dw, dh, s;
        dw = sw / 2;
        dh = sh / 2;
        for (int y = 0; y < dh; y++)
            for (int x = 0; x < dw; x++)
            begin
                s = pyr_at(is_mov, so + 2*y*sw + 2*x) + pyr_at(is_mov, so + 2*y*sw + 2*x + 1)
                  + pyr_at(is_mov, so + (2*y+1)*sw + 2*x)
                  + pyr_at(is_mov, so + (2*y+1)*sw + 2*x + 1);
                if (is_mov)
                    mov_img[dof + y*dw + x] = s >> 2;
                else
                    ref_img[dof + y*dw + x] = s >> 2;
            end
    endfunction

    // Element n/2 of the sorted level, found bit by bit
    function automatic int unsigned upper_median(bit is_mov, int base, int n);
        int unsigned r, cand;
        int below;
        r = 0;
        if (n == 0)
            return 0;
        for (int b = DEF_PIXEL_BITS - 1; b >= 0; b--)
        begin
            cand = r | (32'd1 << b);
            below = 0;
            for (int i = 0; i < n; i++)
                if (pyr_at(is_mov, base + i) < cand)
                    below++;
            if (below <= n / 2)
                r = cand;
        end
        return r;
    endfunction

    function automatic int unsigned shift_score(int ro, int rw, int rh, int mo, int mw, int mh,
                                                int dx, int dy, int unsigned rt,
                                                int unsigned mt);
        longint unsigned miss, over;
        int mx, my;
        bit rb, mb;
        miss = 0;
        over = 0;
        for (int y = 0; y < rh; y++)
        begin
            my = y + dy;
            if (my >= 0 && my < mh)
                for (int x = 0; x < rw; x++)
                begin
                    mx = x + dx;
                    if (mx >= 0 && mx < mw)
                    begin
                        rb = ref_img[ro + y*rw + x] > rt;
                        mb = mov_img[mo + my*mw + mx] > mt;
                        if (rb != mb)
                            miss++;
                        over++;
                    end
                end
        end
        if (over == 0)
            return NO_SCORE;
        return int'((miss * SCORE_SCALE) / over);
    endfunction

    // Coarse-to-fine search over the pyramid
    function automatic shift_t align_shift();
        int rw [MAX_LEV], rh [MAX_LEV], mw [MAX_LEV], mh [MAX_LEV];
        int ro [MAX_LEV], mo [MAX_LEV];
        int levels, p, run_x, run_y, bx, by, cx, cy;
        int unsigned rt, mt, best, e;
        shift_t r;
        rw[0] = clamp_dim(size_reg[CFG_REF_WIDTH], DEF_MAX_WIDTH);
        rh[0] = clamp_dim(size_reg[CFG_REF_HEIGHT], DEF_MAX_HEIGHT);
        mw[0] = clamp_dim(size_reg[CFG_MOV_WIDTH], DEF_MAX_WIDTH);
        mh[0] = clamp_dim(size_reg[CFG_MOV_HEIGHT], DEF_MAX_HEIGHT);
        ro[0] = 0;
        mo[0] = 0;
        levels = 1;
        while (levels < MAX_LEV && rw[levels-1] > DEF_MIN_LEVEL && rh[levels-1] > DEF_MIN_LEVEL)
        begin
            p = levels - 1;
            ro[levels] = ro[p] + rw[p] * rh[p];
            mo[levels] = mo[p] + mw[p] * mh[p];
            shrink_level(1'b0, ro[p], rw[p], rh[p], ro[levels]);
            shrink_level(1'b1, mo[p], mw[p], mh[p], mo[levels]);
            rw[levels] = rw[p] / 2;
            rh[levels] = rh[p] / 2;
            mw[levels] = mw[p] / 2;
            mh[levels] = mh[p] / 2;
            levels++;
        end
        run_x = 0;
        run_y = 0;
        for (int l = levels - 1; l >= 0; l--)
        begin
            run_x *= 2;
            run_y *= 2;
            rt = upper_median(1'b0, ro[l], rw[l] * rh[l]);
            mt = upper_median(1'b1, mo[l], mw[l] * mh[l]);
            best = NO_SCORE;
            bx = run_x;
            by = run_y;
            for (int oy = -1; oy <= 1; oy++)
                for (int ox = -1; ox <= 1; ox++)
                begin
                    cx = run_x + ox;
                    cy = run_y + oy;
                    e = shift_score(ro[l], rw[l], rh[l], mo[l], mw[l], mh[l], cx, cy, rt, mt);
                    if (e < best)
                    begin
                        best = e;
                        bx = cx;
                        by = cy;
                    end
                end
            run_x = bx;
            run_y = by;
        end
        r.sx = run_x[SHIFT_OUT_W-1:0];
        r.sy = run_y[SHIFT_OUT_W-1:0];
        return r;
    endfunction

    // Store one transferred pixel; flag a result when both images are complete
    function automatic bit predict_pixel(logic m, logic [PIX_IN_W-1:0] p,
                                         output shift_t r, output bit stored);
        int unsigned rsize, msize;
        rsize = clamp_dim(size_reg[CFG_REF_WIDTH], DEF_MAX_WIDTH)
              * clamp_dim(size_reg[CFG_REF_HEIGHT], DEF_MAX_HEIGHT);
        msize = clamp_dim(size_reg[CFG_MOV_WIDTH], DEF_MAX_WIDTH)
              * clamp_dim(size_reg[CFG_MOV_HEIGHT], DEF_MAX_HEIGHT);
        stored = 1'b0;
        r = '0;
        if (!m && ref_count < rsize)
        begin
            ref_img[ref_count] = p;
            ref_count++;
            stored = 1'b1;
        end
        else if (m && mov_count < msize)
        begin
            mov_img[mov_count] = p;
            mov_count++;
            stored = 1'b1;
        end
        if (ref_count < rsize || mov_count < msize)
            return 1'b0;
        r = align_shift();
        ref_count = 0;
        mov_count = 0;
        return 1'b1;
    endfunction

    // Lower valid, drain results, then let the block settle
    task automatic wait_idle();
        pix.valid <= 1'b0;
        while (pending_shifts.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    // Drive one register write; the caller lowers cfg_we after the last one
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        size_reg[idx] = val;
        ref_count = 0;
        mov_count = 0;
        cfg_writes++;
    endtask

    task automatic set_sizes(int rw, int rh, int mw, int mh);
        wait_idle();
        write_cfg(CFG_REF_WIDTH, rw[CFG_W-1:0]);
        write_cfg(CFG_REF_HEIGHT, rh[CFG_W-1:0]);
        write_cfg(CFG_MOV_WIDTH, mw[CFG_W-1:0]);
        write_cfg(CFG_MOV_HEIGHT, mh[CFG_W-1:0]);
        cfg_we <= 1'b0;
    endtask

    // Offer one pixel until transferred; returns the prediction
    task automatic send_pixel(logic m, logic [PIX_IN_W-1:0] p, output bit got,
                              output shift_t r);
        bit stored;
        pix.valid <= 1'b1;
        pix.mode  <= m;
        pix.pixel <= p;
        do
            @(posedge clk);
        while (!pix.ready);
        got = predict_pixel(m, p, r, stored);
        if (stored)
            pixels_stored++;
        if (got)
            pending_shifts.push_back(r);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        row_t t;
        t = '{kind: ROW_CFG, idx: idx, val: val, mode: 1'b0, pixel: '0, has_exp: 1'b0, exp: '0};
        dir_rows.push_back(t);
    endfunction

    function automatic void add_pix(logic m, logic [PIX_IN_W-1:0] p, bit chk,
                                    int ex, int ey);
        row_t t;
        t = '{kind: ROW_PIX, idx: '0, val: '0, mode: m, pixel: p, has_exp: chk,
              exp: '{ex[SHIFT_OUT_W-1:0], ey[SHIFT_OUT_W-1:0]}};
        dir_rows.push_back(t);
    endfunction

    // Send one image pair with random content, moving image roughly a shifted copy
    task automatic send_pair(int rw, int rh, int mw, int mh, bit abort);
        int unsigned rimg [$];
        int ri, mi, dx, dy, sx, sy, total;
        logic [PIX_IN_W-1:0] p;
        bit got, m;
        shift_t r;
        rimg = {};
        for (int i = 0; i < rw * rh; i++)
            case ($urandom_range(0, 9))
                0: rimg.push_back(0);
                1: rimg.push_back(16'hFFFF);
                default: rimg.push_back($urandom_range(0, 65535));
            endcase
        dx = $urandom_range(0, 4) - 2;
        dy = $urandom_range(0, 4) - 2;
        ri = 0;
        mi = 0;
        total = rw * rh + mw * mh;
        if (abort)
            total = total / 2;
        while (ri + mi < total)
        begin
            m = (ri >= rw * rh) ? 1'b1 : (mi >= mw * mh) ? 1'b0 : 1'($urandom_range(0, 1));
            if (!m)
            begin
                p = rimg[ri];
                ri++;
            end
            else
            begin
                sx = (mi % mw) - dx;
                sy = (mi / mw) - dy;
                if (sx >= 0 && sx < rw && sy >= 0 && sy < rh && $urandom_range(0, 7) != 0)
                    p = rimg[sy * rw + sx];
                else
                    p = $urandom_range(0, 65535);
                mi++;
            end
            // A noise pixel may go ahead of the last reference pixel, which is then ignored
            if (ri == rw * rh && !m && $urandom_range(0, 15) == 0)
                send_pixel(1'b0, $urandom_range(0, 65535), got, r);
            send_pixel(m, p, got, r);
        end
    endtask

    // Result side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!quiet && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 14);
        res.ready <= (stall_left == 0) && !long_hold;
    end

    initial
    begin
        wait (rand_phase);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Compare each transferred result with the oldest prediction
    always @(posedge clk)
    begin
        shift_t want;
        if (rst_n && res.valid && res.ready)
        begin
            results_seen++;
            if (pending_shifts.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, res.shift_x, res.shift_y);
                errors++;
            end
            else
            begin
                want = pending_shifts.pop_front();
                if (res.shift_x !== want.sx)
                begin
                    $display("%0t: shift_x expected %0d got %0d", $time, want.sx, res.shift_x);
                    errors++;
                end
                if (res.shift_y !== want.sy)
                begin
                    $display("%0t: shift_y expected %0d got %0d", $time, want.sy, res.shift_y);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        bit got;
        shift_t r;
        int rw, rh, mw, mh;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.mode = 1'b0;
        pix.pixel = '0;
        res.ready = 1'b0;
        for (int i = 0; i < 4; i++)
            size_reg[i] = CFG_SIZE_RESET;
        ref_count = 0;
        mov_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: single pixels at the extremes, zero size, ignored and
        // restarted loads, interleaved modes
        add_cfg(CFG_REF_WIDTH, 1);
        add_cfg(CFG_REF_HEIGHT, 1);
        add_cfg(CFG_MOV_WIDTH, 1);
        add_cfg(CFG_MOV_HEIGHT, 1);
        add_pix(0, 16'h0000, 0, 0, 0);
        add_pix(1, 16'hFFFF, 1, 0, 0);
        add_pix(1, 16'h0000, 0, 0, 0);
        add_pix(0, 16'hFFFF, 1, 0, 0);
        add_cfg(CFG_REF_WIDTH, 0);
        add_cfg(CFG_MOV_WIDTH, 2);
        add_pix(0, 16'h1234, 0, 0, 0);
        add_pix(0, 16'hFFFF, 0, 0, 0);
        add_pix(1, 16'h0005, 0, 0, 0);
        add_pix(1, 16'hFFFF, 0, 0, 0);
        add_cfg(CFG_REF_WIDTH, 2);
        add_pix(0, 16'h0007, 0, 0, 0);
        add_cfg(CFG_REF_HEIGHT, 2);
        add_cfg(CFG_MOV_HEIGHT, 2);
        add_pix(0, 16'h8000, 0, 0, 0);
        add_pix(1, 16'h7FFF, 0, 0, 0);
        add_pix(0, 16'h0001, 0, 0, 0);
        add_pix(1, 16'hFFFE, 0, 0, 0);
        add_pix(0, 16'hFFFF, 0, 0, 0);
        add_pix(1, 16'h0000, 0, 0, 0);
        add_pix(0, 16'h0000, 0, 0, 0);
        add_pix(1, 16'hFFFF, 0, 0, 0);

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                if (i == 0 || dir_rows[i-1].kind != ROW_CFG)
                    wait_idle();
                write_cfg(dir_rows[i].idx, dir_rows[i].val);
                if (i + 1 >= dir_rows.size() || dir_rows[i+1].kind != ROW_CFG)
                    cfg_we <= 1'b0;
            end
            else
            begin
                send_pixel(dir_rows[i].mode, dir_rows[i].pixel, got, r);
                if (dir_rows[i].has_exp && (!got || r !== dir_rows[i].exp))
                begin
                    $display("%0t: row %0d expected x=%0d y=%0d predicted x=%0d y=%0d",
                             $time, i, dir_rows[i].exp.sx, dir_rows[i].exp.sy, r.sx, r.sy);
                    errors++;
                end
            end
        end

        // Widest moving image through an oversized width and a zero height
        rand_phase = 1'b1;
        set_sizes(3, 2, 511, 0);
        send_pair(3, 2, 256, 1, 1'b0);

        // Random pairs, mostly small, some deep enough for a pyramid level
        while (pixels_stored < RAND_ITEMS + 300 || results_seen < MIN_RESULTS)
        begin
            if (pixels_stored > RAND_ITEMS + 150)
                quiet = 1'b1;
            if ($urandom_range(0, 14) == 0)
            begin
                rw = $urandom_range(17, 20);
                rh = $urandom_range(17, 20);
                mw = $urandom_range(1, 4);
                mh = $urandom_range(1, 4);
            end
            else
            begin
                rw = $urandom_range(1, 6);
                rh = $urandom_range(1, 6);
                if ($urandom_range(0, 2) == 0)
                begin
                    mw = $urandom_range(1, 6);
                    mh = $urandom_range(1, 6);
                end
                else
                begin
                    mw = rw;
                    mh = rh;
                end
            end
            set_sizes(rw, rh, mw, mh);
            send_pair(rw, rh, mw, mh, $urandom_range(0, 11) == 0);
        end

        // Drain and settle
        pix.valid <= 1'b0;
        while (pending_shifts.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);

        $display("Ran %0d stored pixels, %0d alignments, %0d register writes,",
                 pixels_stored, results_seen, cfg_writes);
        $display("with stalls on both sides and one long result hold-off.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
